[hw/rtl/porl_pkg.sv]
package porl_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
  localparam int ID_W       = 8;
  localparam int PRIO_W     = 8;
  localparam int FILL_W     = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_EMIT
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_priority;
  } in_word_t;

  typedef struct packed {
    stat_t             status;
    logic [ID_W-1:0]   head_id;
    logic [PRIO_W-1:0] head_priority;
    logic              nonempty;
    logic [FILL_W-1:0] fill_count;
  } out_word_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic scan_step;
    logic apply;
    logic emit;
  } porl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } porl_stat_t;

endpackage

[hw/rtl/porl_ctrl.sv]
module porl_ctrl
  import porl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  porl_stat_t stat,
  output porl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_valid;
      end
      S_SCAN: begin
        cmd.scan_step = !stat.scan_done;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hw/rtl/porl_datapath.sv]
module porl_datapath
  import porl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_word_t   in_data,
  input  porl_cmd_t  cmd,
  output porl_stat_t stat,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  logic [ID_W-1:0]   slot_id_r   [TASK_SLOTS];
  logic [PRIO_W-1:0] slot_prio_r [TASK_SLOTS];
  logic [ID_W-1:0]   id_prev     [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_prev   [TASK_SLOTS];
  logic [ID_W-1:0]   id_next     [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_next   [TASK_SLOTS];

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CNT_W-1:0]  pos_r;
  in_word_t          req_r;
  stat_t             status_r;
  stat_t             status_nxt;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic [ID_W-1:0]   cur_id;
  logic [PRIO_W-1:0] cur_prio;
  logic              at_end;
  logic              full;
  logic              found;
  logic              do_ins;
  logic              do_rem;

  genvar g;
  generate
    for (g = 0; g < TASK_SLOTS; g++) begin : g_nbr
      if (g == 0) begin : g_first
        assign id_prev[g]   = req_r.task_id;
        assign prio_prev[g] = req_r.task_priority;
      end else begin : g_rest
        assign id_prev[g]   = slot_id_r[g-1];
        assign prio_prev[g] = slot_prio_r[g-1];
      end
      if (g == TASK_SLOTS - 1) begin : g_last
        assign id_next[g]   = slot_id_r[g];
        assign prio_next[g] = slot_prio_r[g];
      end else begin : g_inner
        assign id_next[g]   = slot_id_r[g+1];
        assign prio_next[g] = slot_prio_r[g+1];
      end
    end
  endgenerate

  assign cur_id   = slot_id_r[pos_r[SLOT_W-1:0]];
  assign cur_prio = slot_prio_r[pos_r[SLOT_W-1:0]];
  assign at_end   = (pos_r >= count_r);
  assign full     = (count_r >= CNT_W'(TASK_SLOTS));
  assign found    = !at_end;

  always_comb begin
    stat.out_free = !out_valid_r || out_ready;
    if (at_end) begin
      stat.scan_done = 1'b1;
    end else if (req_r.kind == KIND_INSERT) begin
      stat.scan_done = (req_r.task_priority > cur_prio);
    end else begin
      stat.scan_done = (req_r.task_id == cur_id);
    end
  end

  assign do_ins = cmd.apply && (req_r.kind == KIND_INSERT) && !full;
  assign do_rem = cmd.apply && (req_r.kind == KIND_REMOVE) && found;

  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    if (cmd.apply) begin
      if (req_r.kind == KIND_INSERT) begin
        status_nxt = full ? STAT_FULL : STAT_DONE;
      end else begin
        status_nxt = found ? STAT_DONE : STAT_NOT_FOUND;
      end
    end
    if (do_ins) count_nxt = count_r + CNT_W'(1);
    if (do_rem) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load) begin
        pos_r <= '0;
      end else if (cmd.scan_step) begin
        pos_r <= pos_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    status_r <= status_nxt;
    for (int k = 0; k < TASK_SLOTS; k++) begin
      if (do_ins) begin
        if (CNT_W'(k) == pos_r) begin
          slot_id_r[k]   <= req_r.task_id;
          slot_prio_r[k] <= req_r.task_priority;
        end else if (CNT_W'(k) > pos_r && CNT_W'(k) <= count_r) begin
          slot_id_r[k]   <= id_prev[k];
          slot_prio_r[k] <= prio_prev[k];
        end
      end else if (do_rem) begin
        if (CNT_W'(k) >= pos_r && (CNT_W'(k) + CNT_W'(1)) < count_r) begin
          slot_id_r[k]   <= id_next[k];
          slot_prio_r[k] <= prio_next[k];
        end
      end
    end
    if (cmd.emit) begin
      out_data_r.status     <= status_r;
      out_data_r.nonempty   <= (count_r != '0);
      out_data_r.fill_count <= FILL_W'(count_r);
      if (count_r != '0) begin
        out_data_r.head_id       <= slot_id_r[0];
        out_data_r.head_priority <= slot_prio_r[0];
      end else begin
        out_data_r.head_id       <= '0;
        out_data_r.head_priority <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/priority_ordered_ready_list.sv]
// Ready list of task identifiers kept in descending priority order,
// equal priorities in arrival order, up to TASK_SLOTS entries.
// Input channel (in_valid/in_ready/in_data): one word per request, an
// insert of task_id at task_priority or a remove of task_id.
// Result channel (out_valid/out_ready/out_data): one word per request with
// status, head task, head priority, nonempty flag and fill count.
// The search stops at a slot from 0 to TASK_SLOTS and walks one slot per
// cycle; the shift is done in the apply state. One request is in work at a
// time and the next is taken once the result is registered.
// A new request is accepted while the previous result still waits; a
// stalled receiver holds the result word and the finished request waits
// until the output register is free.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; slot contents are never read beyond the fill count.
module priority_ordered_ready_list
  import porl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  porl_cmd_t  cmd;
  porl_stat_t stat;

  porl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  porl_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = cmd.in_ready;

endmodule

[tb/priority_ordered_ready_list_check.sv]
`timescale 1ns / 100ps

module priority_ordered_ready_list_check
  import porl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        mismatch_count,
  output int        results_owed
);

  logic [ID_W-1:0]   list_ids   [TASK_SLOTS];
  logic [PRIO_W-1:0] list_prios [TASK_SLOTS];
  int                list_fill;
  out_word_t         pending_results[$];

  task automatic apply_to_list(input in_word_t w);
    out_word_t r;
    int        pos;
    int        k;
    r   = '0;
    pos = 0;
    if (w.kind == KIND_INSERT) begin
      if (list_fill >= TASK_SLOTS) begin
        r.status = STAT_FULL;
      end else begin
        while (pos < list_fill && w.task_priority <= list_prios[pos]) pos++;
        for (k = list_fill; k > pos; k--) begin
          list_ids[k]   = list_ids[k-1];
          list_prios[k] = list_prios[k-1];
        end
        list_ids[pos]   = w.task_id;
        list_prios[pos] = w.task_priority;
        list_fill++;
        r.status = STAT_DONE;
      end
    end else begin
      while (pos < list_fill && list_ids[pos] != w.task_id) pos++;
      if (pos >= list_fill) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        for (k = pos; k + 1 < list_fill; k++) begin
          list_ids[k]   = list_ids[k+1];
          list_prios[k] = list_prios[k+1];
        end
        list_fill--;
        r.status = STAT_DONE;
      end
    end
    if (list_fill > 0) begin
      r.head_id       = list_ids[0];
      r.head_priority = list_prios[0];
      r.nonempty      = 1'b1;
    end
    r.fill_count = FILL_W'(list_fill);
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      pending_results.delete();
      list_fill      = 0;
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with no request pending: %h", out_data);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data.status);
            mismatch_count++;
          end
          if (out_data.head_id !== want.head_id) begin
            $error("head_id expected %0d actual %0d", want.head_id, out_data.head_id);
            mismatch_count++;
          end
          if (out_data.head_priority !== want.head_priority) begin
            $error("head_priority expected %0d actual %0d", want.head_priority,
                   out_data.head_priority);
            mismatch_count++;
          end
          if (out_data.nonempty !== want.nonempty) begin
            $error("nonempty expected %0d actual %0d", want.nonempty, out_data.nonempty);
            mismatch_count++;
          end
          if (out_data.fill_count !== want.fill_count) begin
            $error("fill_count expected %0d actual %0d", want.fill_count,
                   out_data.fill_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) apply_to_list(in_data);
    end
    results_owed = pending_results.size();
  end

endmodule

[tb/priority_ordered_ready_list_test.sv]
`timescale 1ns / 100ps

module priority_ordered_ready_list_test;
  import porl_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;
  int        mismatch_count;
  int        results_owed;

  bit        calm;
  bit        hold_req;
  int        sender_odds;

  priority_ordered_ready_list uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  priority_ordered_ready_list_check chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // send one word; entered and left at a falling edge
  task automatic send_word(input in_word_t w);
    if (!calm && sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(input kind_t k, input int id, input int prio);
    in_word_t w;
    w.kind          = k;
    w.task_id       = ID_W'(id);
    w.task_priority = PRIO_W'(prio);
    send_word(w);
  endtask

  task automatic drain_list_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  function automatic in_word_t random_word(input int insert_pct);
    in_word_t w;
    w.kind          = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
    w.task_id       = ($urandom_range(0, 3) == 0) ? ID_W'($urandom)
                                                   : ID_W'($urandom_range(0, 15));
    w.task_priority = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 3))
                                                   : PRIO_W'($urandom);
    return w;
  endfunction

  initial begin : result_sink
    int segment_left;
    int idle_odds;
    int quiet_left;
    int hold_left;
    bit hold_done;
    out_ready    = 1'b0;
    segment_left = 0;
    idle_odds    = 0;
    quiet_left   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (segment_left == 0) begin
        segment_left = 64;
        idle_odds    = ($urandom_range(0, 3) == 0) ? 0 : 6;
      end
      segment_left--;
      if (hold_req && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_ready <= 1'b0;
      end else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        quiet_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int n;
    int i;
    int seg_left;
    int insert_pct;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    sender_odds = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_op(KIND_REMOVE, 5, 0);
    send_op(KIND_INSERT, 0, 0);
    send_op(KIND_INSERT, 255, 255);
    send_op(KIND_INSERT, 7, 255);
    send_op(KIND_INSERT, 7, 10);
    send_op(KIND_INSERT, 9, 0);
    send_op(KIND_REMOVE, 7, 255);
    send_op(KIND_REMOVE, 99, 0);
    for (i = 0; i < 11; i++) send_op(KIND_INSERT, 20 + i, (i * 47) % 256);
    send_op(KIND_INSERT, 254, 128);
    send_op(KIND_REMOVE, 255, 0);
    send_op(KIND_REMOVE, 0, 0);
    drain_list_results();

    seg_left   = 0;
    insert_pct = 50;
    for (n = 0; n < 500; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 25;
          default: insert_pct = 55;
        endcase
        sender_odds = ($urandom_range(0, 3) == 0) ? 0 : 5;
      end
      seg_left--;
      if (n == 150) hold_req = 1'b1;
      if (n == 300) drain_list_results();
      if (n == 420) calm = 1'b1;
      send_word(random_word(insert_pct));
    end

    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
